[hdl/arm_pkg.sv]
// Shared types, constants and helpers for the axis-angle rotation matrix block.
// No dependencies; imported by the top level and the testbench.
package arm_pkg;

    localparam int ANGLE_W = 16;
    localparam int COMP_W  = 16;
    localparam int CRD_W   = 34;          // CORDIC x/y in Q2.30, z in 2^-32 turn, with headroom
    localparam int T_W     = CRD_W + 1;   // t = 1 - c
    localparam int SA_W    = CRD_W + COMP_W;
    localparam int AA_W    = 2 * COMP_W;
    localparam int TP_W    = T_W + AA_W;
    localparam int SUM_W   = 41;
    localparam logic signed [CRD_W-1:0] CORDIC_X0 = 34'sd652032874;
    localparam logic signed [T_W-1:0]   ONE_Q30   = 35'sd1073741824;

    typedef struct packed {
        logic signed [COMP_W-1:0] x;
        logic signed [COMP_W-1:0] y;
        logic signed [COMP_W-1:0] z;
    } axis_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [CRD_W-1:0] atan_val(input int i);
        logic [CRD_W-1:0] r;
        case (i)
            0:  r = 34'd536870912;
            1:  r = 34'd316933406;
            2:  r = 34'd167458907;
            3:  r = 34'd85004756;
            4:  r = 34'd42667331;
            5:  r = 34'd21354465;
            6:  r = 34'd10679838;
            7:  r = 34'd5340245;
            8:  r = 34'd2670163;
            9:  r = 34'd1335087;
            10: r = 34'd667544;
            11: r = 34'd333772;
            12: r = 34'd166886;
            13: r = 34'd83443;
            14: r = 34'd41722;
            15: r = 34'd20861;
            16: r = 34'd10430;
            17: r = 34'd5215;
            18: r = 34'd2608;
            19: r = 34'd1304;
            20: r = 34'd652;
            21: r = 34'd326;
            22: r = 34'd163;
            23: r = 34'd81;
            24: r = 34'd41;
            25: r = 34'd20;
            26: r = 34'd10;
            27: r = 34'd5;
            28: r = 34'd3;
            29: r = 34'd1;
            30: r = 34'd1;
            default: r = 34'd0;
        endcase
        return r;
    endfunction

    // Round Q30 to Q14 half up, then saturate
    function automatic logic [COMP_W-1:0] to_q14(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] r;
        logic [COMP_W-1:0] q;
        r = (v + SUM_W'(32768)) >>> 16;
        if (r > SUM_W'(32767))
            q = 16'h7FFF;
        else if (r < -SUM_W'(32768))
            q = 16'h8000;
        else
            q = r[COMP_W-1:0];
        return q;
    endfunction

endpackage

[hdl/axis_angle_rotation_matrix.sv]
// Rodrigues rotation matrix from a binary angle and a Q1.14 axis.
// Depends on arm_pkg (widths, CORDIC angle table, Q14 rounding).
//
// Channel  Dir  tdata layout (low bit up)                     Notes
// s_axis   in   angle, axis_x, axis_y, axis_z (64 bits)       one request per item
// m_axis   out  m00 m01 m02 m10 m11 m12 m20 m21 m22 (144)     one result per request
//
// The pipeline has one prep stage, one stage per CORDIC step, two multiply stages
// and the output register. A request is taken every cycle unless the output stalls.
// Stalls freeze the whole pipeline at once; s_tready is low only while a result
// waits at the output and m_tready is low. Reset clears all valid bits.
module axis_angle_rotation_matrix
    import arm_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // angle, axis_x, axis_y, axis_z
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata    // m00, m01, m02, m10, m11, m12, m20, m21, m22
);

    localparam int N = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // CORDIC pipeline, index 0 is the prep stage
    logic                    v_reg    [0:N];
    logic signed [CRD_W-1:0] x_reg    [0:N];
    logic signed [CRD_W-1:0] y_reg    [0:N];
    logic signed [CRD_W-1:0] z_reg    [0:N];
    logic                    flip_reg [0:N];
    axis_t                   ax_reg   [0:N];

    logic [ANGLE_W-1:0] in_angle;
    logic               in_flip;
    assign in_angle = s_tdata[15:0];
    assign in_flip  = in_angle[15] ^ in_angle[14];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (adv)
            v_reg[0] <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // fold the angle into [-90, 90) degrees, flip signs at the end
            z_reg[0]    <= CRD_W'($signed({in_angle[15] ^ in_flip, in_angle[14:0], 16'h0}));
            x_reg[0]    <= CORDIC_X0;
            y_reg[0]    <= '0;
            flip_reg[0] <= in_flip;
            ax_reg[0]   <= {s_tdata[31:16], s_tdata[47:32], s_tdata[63:48]};
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_cordic
        logic signed [CRD_W-1:0] dx, dy, at;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        assign at = $signed(atan_val(i));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else if (adv)
                v_reg[i+1] <= v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (!z_reg[i][CRD_W-1])
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - at;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + at;
                end
                flip_reg[i+1] <= flip_reg[i];
                ax_reg[i+1]   <= ax_reg[i];
            end
        end
    end

    // Multiply stage 1: t, s*a and a*b products
    logic signed [CRD_W-1:0] c_next, s_next;
    axis_t                   a_n;
    assign c_next = flip_reg[N] ? -x_reg[N] : x_reg[N];
    assign s_next = flip_reg[N] ? -y_reg[N] : y_reg[N];
    assign a_n    = ax_reg[N];

    logic                    v1_reg;
    logic signed [CRD_W-1:0] c1_reg;
    logic signed [T_W-1:0]   t1_reg;
    logic signed [SA_W-1:0]  sx1_reg, sy1_reg, sz1_reg;
    logic signed [AA_W-1:0]  xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg;

    // Multiply stage 2: t*a*b
    logic                    v2_reg;
    logic signed [CRD_W-1:0] c2_reg;
    logic signed [SA_W-1:0]  sx2_reg, sy2_reg, sz2_reg;
    logic signed [TP_W-1:0]  txx_reg, tyy_reg, tzz_reg, txy_reg, txz_reg, tyz_reg;

    logic           out_v_reg;
    logic [143:0]   out_reg;
    logic [143:0]   out_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg    <= v_reg[N];
            v2_reg    <= v1_reg;
            out_v_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1_reg  <= c_next;
            t1_reg  <= ONE_Q30 - T_W'(c_next);
            sx1_reg <= s_next * a_n.x;
            sy1_reg <= s_next * a_n.y;
            sz1_reg <= s_next * a_n.z;
            xx_reg  <= a_n.x * a_n.x;
            yy_reg  <= a_n.y * a_n.y;
            zz_reg  <= a_n.z * a_n.z;
            xy_reg  <= a_n.x * a_n.y;
            xz_reg  <= a_n.x * a_n.z;
            yz_reg  <= a_n.y * a_n.z;

            c2_reg  <= c1_reg;
            sx2_reg <= sx1_reg;
            sy2_reg <= sy1_reg;
            sz2_reg <= sz1_reg;
            txx_reg <= t1_reg * xx_reg;
            tyy_reg <= t1_reg * yy_reg;
            tzz_reg <= t1_reg * zz_reg;
            txy_reg <= t1_reg * xy_reg;
            txz_reg <= t1_reg * xz_reg;
            tyz_reg <= t1_reg * yz_reg;

            out_reg <= out_next;
        end
    end

    // Output stage: scale to Q30, combine, round and saturate
    logic signed [SUM_W-1:0] c_w, sx_w, sy_w, sz_w;
    logic signed [SUM_W-1:0] pxx, pyy, pzz, pxy, pxz, pyz;

    assign c_w  = SUM_W'(c2_reg);
    assign sx_w = SUM_W'($signed(sx2_reg[SA_W-1:14]));
    assign sy_w = SUM_W'($signed(sy2_reg[SA_W-1:14]));
    assign sz_w = SUM_W'($signed(sz2_reg[SA_W-1:14]));
    assign pxx  = SUM_W'($signed(txx_reg[TP_W-1:28]));
    assign pyy  = SUM_W'($signed(tyy_reg[TP_W-1:28]));
    assign pzz  = SUM_W'($signed(tzz_reg[TP_W-1:28]));
    assign pxy  = SUM_W'($signed(txy_reg[TP_W-1:28]));
    assign pxz  = SUM_W'($signed(txz_reg[TP_W-1:28]));
    assign pyz  = SUM_W'($signed(tyz_reg[TP_W-1:28]));

    assign out_next = {
        to_q14(c_w + pzz),
        to_q14(pyz + sx_w),
        to_q14(pxz - sy_w),
        to_q14(pyz - sx_w),
        to_q14(c_w + pyy),
        to_q14(pxy + sz_w),
        to_q14(pxz + sy_w),
        to_q14(pxy - sz_w),
        to_q14(c_w + pxx)
    };

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg;

endmodule

[hdl/arm_chk.sv]
// Port-level checker for the axis-angle rotation matrix block, with its bind.
// Depends on the top level's port list only.
module arm_chk (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [143:0] m_tdata
);

    // the pipeline stalls only on a held result
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow output stall");

    // a result appears only on a cycle the pipeline advanced
    a_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tready))
        else $error("result appeared during a stall");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

endmodule

bind axis_angle_rotation_matrix arm_chk u_arm_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[verif/tb_axis_angle_rotation_matrix.sv]
// Testbench for axis_angle_rotation_matrix: directed table then random requests,
// each result checked against a built-in Rodrigues/CORDIC predictor.
// Depends on arm_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_axis_angle_rotation_matrix;
    import arm_pkg::*;

    localparam int STEPS    = 16;
    localparam int N_RANDOM = 1600;
    localparam int WD_LIMIT = 20000;

    typedef struct {
        logic [15:0]        angle;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        bit                 has_exp;
        logic [143:0]       exp;
    } req_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [63:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [143:0] m_tdata;

    logic [143:0] matrix_q[$];
    logic [143:0] typed_q[$];
    bit           typed_flag_q[$];
    req_row_t     dir_rows[$];
    int           errors;
    int           idle_cycles;
    bit           no_idle;
    bit           hold_off;

    axis_angle_rotation_matrix #(.CORDIC_STEPS(STEPS)) u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint shr_floor(longint v, int sh);
        return v >>> sh;
    endfunction

    function automatic logic [15:0] round_sat(longint v30);
        longint r;
        r = (v30 + 32768) >>> 16;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[15:0];
    endfunction

    function automatic logic [143:0] rotation_matrix(logic [15:0] angle,
            logic signed [15:0] ax16, logic signed [15:0] ay16, logic signed [15:0] az16);
        longint atan_rom[32] = '{536870912, 316933406, 167458907, 85004756, 42667331,
            21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
            83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
            10, 5, 3, 1, 1, 0};
        logic [31:0] a32;
        bit      flip;
        longint  x, y, z, dx, dy, c, s, t, ax, ay, az, cxy, cxz, cyz, sx, sy, sz;
        logic [15:0] m[9];
        a32 = {angle, 16'h0};
        flip = 0;
        ax = ax16;
        ay = ay16;
        az = az16;
        if (a32 >= 32'h4000_0000 && a32 < 32'hC000_0000)
        begin
            flip = 1;
            a32 = a32 - 32'h8000_0000;
        end
        z = longint'($signed(a32));
        x = 652032874;
        y = 0;
        for (int i = 0; i < STEPS && i < 32; i++)
        begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= atan_rom[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += atan_rom[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
        t = 64'sd1073741824 - c;
        cxy = (t * (ax * ay)) >>> 28;
        cxz = (t * (ax * az)) >>> 28;
        cyz = (t * (ay * az)) >>> 28;
        sx = (s * ax) >>> 14;
        sy = (s * ay) >>> 14;
        sz = (s * az) >>> 14;
        m[0] = round_sat(c + ((t * (ax * ax)) >>> 28));
        m[1] = round_sat(cxy - sz);
        m[2] = round_sat(cxz + sy);
        m[3] = round_sat(cxy + sz);
        m[4] = round_sat(c + ((t * (ay * ay)) >>> 28));
        m[5] = round_sat(cyz - sx);
        m[6] = round_sat(cxz - sy);
        m[7] = round_sat(cyz + sx);
        m[8] = round_sat(c + ((t * (az * az)) >>> 28));
        return {m[8], m[7], m[6], m[5], m[4], m[3], m[2], m[1], m[0]};
    endfunction

    task automatic add_row(logic [15:0] a, logic [15:0] x, logic [15:0] y,
            logic [15:0] z, bit typed, logic [143:0] e);
        req_row_t r;
        r.angle = a;
        r.ax = x;
        r.ay = y;
        r.az = z;
        r.has_exp = typed;
        r.exp = e;
        dir_rows.push_back(r);
    endtask

    task automatic send_request(logic [15:0] a, logic [15:0] x, logic [15:0] y,
            logic [15:0] z, bit typed, logic [143:0] e);
        int gap;
        if (!no_idle && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 13);
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {z, y, x, a};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        matrix_q.push_back(rotation_matrix(a, x, y, z));
        typed_q.push_back(e);
        typed_flag_q.push_back(typed);
        @(negedge clk);
    endtask

    // receiver: random stalls, one long hold-off
    initial
    begin
        int gap;
        m_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                m_tready <= 1'b0;
                repeat (300) @(negedge clk);
                hold_off = 0;
            end
            else if (!no_idle && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                gap = $urandom_range(1, 13);
                repeat (gap - 1) @(negedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        logic [143:0] e, te;
        bit tf;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (matrix_q.size() == 0)
            begin
                $error("result with no request pending: %h", m_tdata);
                errors++;
            end
            else
            begin
                e = matrix_q.pop_front();
                te = typed_q.pop_front();
                tf = typed_flag_q.pop_front();
                if (tf && te !== e)
                begin
                    $error("table row disagrees with predictor: %h vs %h", te, e);
                    errors++;
                end
                for (int k = 0; k < 9; k++)
                    if (m_tdata[k*16 +: 16] !== e[k*16 +: 16])
                    begin
                        $error("m%0d%0d expected %0d actual %0d", k / 3, k % 3,
                               $signed(e[k*16 +: 16]), $signed(m_tdata[k*16 +: 16]));
                        errors++;
                    end
            end
        end
    end

    // watchdog on cycles without any accepted request or result
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WD_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] rx, ry, rz, a;
        logic [143:0] ident;
        errors = 0;
        idle_cycles = 0;
        no_idle = 0;
        hold_off = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        ident = {16'sd16384, 16'd0, 16'd0, 16'd0, 16'sd16384, 16'd0, 16'd0, 16'd0,
                 16'sd16384};
        // zero axis and zero angle: matrix is the identity
        add_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, ident);
        add_row(16'h0000, 16'h4000, 16'h0000, 16'h0000, 0, '0);
        add_row(16'h4000, 16'h0000, 16'h0000, 16'h4000, 0, '0);
        add_row(16'h8000, 16'h0000, 16'h4000, 16'h0000, 0, '0);
        add_row(16'hC000, 16'h4000, 16'h0000, 16'h0000, 0, '0);
        add_row(16'h3FFF, 16'h2D41, 16'h2D41, 16'h0000, 0, '0);
        add_row(16'hBFFF, 16'h24F3, 16'h24F3, 16'h24F3, 0, '0);
        add_row(16'hFFFF, 16'hC000, 16'h0000, 16'h0000, 0, '0);
        add_row(16'h7FFF, 16'h0000, 16'hC000, 16'h0000, 0, '0);
        // non-unit axes saturate: all ones in magnitude
        add_row(16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1,
                {9{16'h7FFF}} & 144'h0 | {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF});
        add_row(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1,
                {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                 16'h7FFF, 16'h7FFF, 16'h7FFF});
        add_row(16'h4000, 16'h7FFF, 16'h8000, 16'h7FFF, 0, '0);
        add_row(16'h2000, 16'h8000, 16'h7FFF, 16'h8000, 0, '0);
        add_row(16'hE000, 16'h1234, 16'hFEDC, 16'h5555, 0, '0);
        add_row(16'h0001, 16'hAAAA, 16'h5555, 16'hFFFF, 0, '0);
        add_row(16'h5555, 16'h0001, 16'hFFFE, 16'h8001, 0, '0);
        add_row(16'hAAAA, 16'h3FFF, 16'h4001, 16'hC001, 0, '0);
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        foreach (dir_rows[i])
            send_request(dir_rows[i].angle, dir_rows[i].ax, dir_rows[i].ay,
                         dir_rows[i].az, dir_rows[i].has_exp, dir_rows[i].exp);
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == 400)
                hold_off = 1;
            if (n == N_RANDOM - 200)
                no_idle = 1;
            a = $urandom;
            if ($urandom_range(0, 3) != 0)
            begin
                // axis with component magnitudes summing to 1.0, random signs
                rx = $urandom_range(0, 16384);
                ry = $urandom_range(0, 16384 - rx);
                rz = 16384 - rx - ry;
                if ($urandom_range(0, 1)) rx = -rx;
                if ($urandom_range(0, 1)) ry = -ry;
                if ($urandom_range(0, 1)) rz = -rz;
            end
            else
            begin
                rx = $urandom;
                ry = $urandom;
                rz = $urandom;
            end
            send_request(a, rx, ry, rz, 0, '0);
        end
        s_tvalid <= 1'b0;
        while (matrix_q.size() != 0)
            @(posedge clk);
        repeat (STEPS + 10) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[sim.f]
hdl/arm_pkg.sv
hdl/axis_angle_rotation_matrix.sv
hdl/arm_chk.sv
verif/tb_axis_angle_rotation_matrix.sv
